// File: rtl/spuv_pkg.sv
// shared constants and types for the spherical uv generator
`timescale 1ns / 1ps
package spuv_pkg;

  localparam int COORD_WIDTH_DEF      = 32;
  localparam int UV_FRAC_BITS_DEF     = 16;
  localparam int ANGLE_ITERATIONS_DEF = 16;

  // magnitudes after the common scaling lie below 2^31
  localparam int NORM_W = 31;
  localparam int OUT_W  = 16;

  localparam int FIFO_DEPTH  = 8;
  localparam int FRONT_DEPTH = 4;
  localparam int FRONT_LAT   = 4;

  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_CENTER_Z = 2'd2;

  // atan(2^-i) in turns, 2^32 per turn
  localparam logic [31:0] ATAN_TURNS [0:31] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic              degenerate;
    logic              neg_x;
    logic              neg_y;
    logic              neg_z;
    logic [NORM_W-1:0] ax;
    logic [NORM_W-1:0] ay;
    logic [NORM_W-1:0] az;
  } spuv_item_t;

  typedef struct packed {
    logic              valid;
    logic              degenerate;
    logic              sy_pos;
    logic [NORM_W-1:0] ay;
  } spuv_side_t;

endpackage

// File: rtl/spuv_front.sv
// front end: difference, magnitude and common scaling of each transaction
`timescale 1ns / 1ps
module spuv_front #(
  parameter int COORD_WIDTH = spuv_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic signed [COORD_WIDTH-1:0] vertex_x,
  input  logic signed [COORD_WIDTH-1:0] vertex_y,
  input  logic signed [COORD_WIDTH-1:0] vertex_z,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic signed [COORD_WIDTH-1:0] center_z,
  output logic                          push,
  output spuv_pkg::spuv_item_t          item
);
  import spuv_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = $clog2(DW);

  logic                 v1, v2, v3;
  logic signed [DW-1:0] dx, dy, dz;
  logic [DW-1:0]        mx, my, mz, mx3, my3, mz3;
  logic                 nx, ny, nz, nx3, ny3, nz3;
  logic [DW-1:0]        mor;
  logic [PW-1:0]        msb, msb_next;
  logic                 zero3;
  logic [DW+NORM_W-2:0] wx, wy, wz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    dx <= DW'(center_x) - DW'(vertex_x);
    dy <= DW'(center_y) - DW'(vertex_y);
    dz <= DW'(center_z) - DW'(vertex_z);
    nx <= dx[DW-1];
    ny <= dy[DW-1];
    nz <= dz[DW-1];
    mx <= dx[DW-1] ? DW'(-dx) : DW'(dx);
    my <= dy[DW-1] ? DW'(-dy) : DW'(dy);
    mz <= dz[DW-1] ? DW'(-dz) : DW'(dz);
    mx3 <= mx;
    my3 <= my;
    mz3 <= mz;
    nx3 <= nx;
    ny3 <= ny;
    nz3 <= nz;
    msb <= msb_next;
    zero3 <= (mor == '0);
  end

  // leading one of the or of the magnitudes is the leading one of the largest
  always_comb begin
    mor = mx | my | mz;
    msb_next = '0;
    for (int i = 0; i < DW; i++) begin
      if (mor[i]) msb_next = PW'(i);
    end
  end

  // scale so the largest magnitude sits in [2^30, 2^31)
  assign wx = {mx3, {(NORM_W-1){1'b0}}} >> msb;
  assign wy = {my3, {(NORM_W-1){1'b0}}} >> msb;
  assign wz = {mz3, {(NORM_W-1){1'b0}}} >> msb;

  assign push = v3;
  always_comb begin
    item.degenerate = zero3;
    item.neg_x      = nx3;
    item.neg_y      = ny3;
    item.neg_z      = nz3;
    item.ax         = wx[NORM_W-1:0];
    item.ay         = wy[NORM_W-1:0];
    item.az         = wz[NORM_W-1:0];
  end

endmodule

// File: rtl/spuv_fifo.sv
// short queue between the front end and the arithmetic back end
`timescale 1ns / 1ps
module spuv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           din,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic             do_rd;

  assign empty = (count == '0);
  assign do_rd = rd_en && !empty;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CW'(wr_en) - CW'(do_rd);
    end
  end

endmodule

// File: rtl/spuv_cordic.sv
// pipelined vectoring cordic giving the horizontal coordinate
`timescale 1ns / 1ps
module spuv_cordic #(
  parameter int ANGLE_ITERATIONS = spuv_pkg::ANGLE_ITERATIONS_DEF,
  parameter int UV_FRAC_BITS     = spuv_pkg::UV_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  spuv_pkg::spuv_item_t      item,
  output logic [UV_FRAC_BITS-1:0]   u
);
  import spuv_pkg::*;

  localparam int XW = 36;
  localparam logic signed [XW-1:0] QUARTER = XW'(64'sd1 <<< 30);
  localparam logic signed [XW-1:0] A_HALF  = XW'(64'sd1 <<< 31);
  localparam logic signed [XW-1:0] RND     = XW'(64'sd1 <<< (31 - UV_FRAC_BITS));
  localparam logic signed [XW-1:0] UMAX    = XW'((64'sd1 <<< UV_FRAC_BITS) - 1);

  logic signed [XW-1:0] cx [0:ANGLE_ITERATIONS];
  logic signed [XW-1:0] cy [0:ANGLE_ITERATIONS];
  logic signed [XW-1:0] ca [0:ANGLE_ITERATIONS];
  logic signed [XW-1:0] sx, sz, ang, rr;

  assign sx = item.neg_x ? -XW'(item.ax) : XW'(item.ax);
  assign sz = item.neg_z ? -XW'(item.az) : XW'(item.az);

  // quarter-turn pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (sx < 0) begin
      if (sz >= 0) begin
        cx[0] <= sz;
        cy[0] <= -sx;
        ca[0] <= QUARTER;
      end else begin
        cx[0] <= -sz;
        cy[0] <= sx;
        ca[0] <= -QUARTER;
      end
    end else begin
      cx[0] <= sx;
      cy[0] <= sz;
      ca[0] <= '0;
    end
  end

  for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (cy[i] > 0) begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        ca[i+1] <= ca[i] + XW'(ATAN_TURNS[i]);
      end else begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        ca[i+1] <= ca[i] - XW'(ATAN_TURNS[i]);
      end
    end
  end

  assign ang = ca[ANGLE_ITERATIONS] + A_HALF;
  assign rr  = (ang + RND) >>> (32 - UV_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (ang < 0) u <= '0;
    else if (rr > UMAX) u <= UMAX[UV_FRAC_BITS-1:0];
    else u <= rr[UV_FRAC_BITS-1:0];
  end

endmodule

// File: rtl/spuv_vnorm.sv
// squares, square root and divide pipeline giving the vertical coordinate
`timescale 1ns / 1ps
module spuv_vnorm #(
  parameter int UV_FRAC_BITS = spuv_pkg::UV_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  spuv_pkg::spuv_item_t    item,
  output logic                    out_valid,
  output logic                    out_degenerate,
  output logic [UV_FRAC_BITS-1:0] v
);
  import spuv_pkg::*;

  localparam int SQ_STEPS = 32;
  localparam int UVF = UV_FRAC_BITS;
  localparam logic [UVF:0] HALF = (UVF+1)'(1) << (UVF - 1);
  localparam logic [UVF:0] VMAX = ((UVF+1)'(1) << UVF) - 1'b1;

  // side[0] mult, [1] sum, [2..33] root, [34] prep, then divide steps
  localparam int NSIDE = SQ_STEPS + 3 + UVF;

  spuv_side_t  side [0:NSIDE-1];
  spuv_side_t  side_in;
  logic [61:0] sqx, sqy, sqz;
  logic [63:0] rn [0:SQ_STEPS];
  logic [63:0] rr [0:SQ_STEPS];
  logic [63:0] rem [0:UVF];
  logic [63:0] den [0:UVF];
  logic [UVF-1:0] quo [0:UVF];
  logic [UVF:0] t_ext, v_calc;

  always_comb begin
    side_in.valid      = in_valid;
    side_in.degenerate = item.degenerate;
    side_in.sy_pos     = !item.neg_y && (item.ay != '0);
    side_in.ay         = item.ay;
  end

  // valid flags are reset, the data beside them simply follows
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSIDE; k++) side[k].valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      side[0].valid <= side_in.valid;
      for (int k = 1; k < NSIDE; k++) side[k].valid <= side[k-1].valid;
      out_valid <= side[NSIDE-1].valid;
    end
    side[0].degenerate <= side_in.degenerate;
    side[0].sy_pos     <= side_in.sy_pos;
    side[0].ay         <= side_in.ay;
    for (int k = 1; k < NSIDE; k++) begin
      side[k].degenerate <= side[k-1].degenerate;
      side[k].sy_pos     <= side[k-1].sy_pos;
      side[k].ay         <= side[k-1].ay;
    end
    sqx   <= 62'(item.ax) * 62'(item.ax);
    sqy   <= 62'(item.ay) * 62'(item.ay);
    sqz   <= 62'(item.az) * 62'(item.az);
    rn[0] <= 64'(sqx) + 64'(sqy) + 64'(sqz);
    rr[0] <= '0;
  end

  // one result bit of the integer square root per stage
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
    logic [63:0] trial;
    assign trial = rr[k] + BIT;
    always_ff @(posedge clk) begin
      if (rn[k] >= trial) begin
        rn[k+1] <= rn[k] - trial;
        rr[k+1] <= (rr[k] >> 1) + BIT;
      end else begin
        rn[k+1] <= rn[k];
        rr[k+1] <= rr[k] >> 1;
      end
    end
  end

  // rounded numerator for the restoring divide
  always_ff @(posedge clk) begin
    rem[0] <= (64'(side[SQ_STEPS+1].ay) << (UVF - 1)) + (rr[SQ_STEPS] >> 1);
    den[0] <= rr[SQ_STEPS];
    quo[0] <= '0;
  end

  for (genvar j = 0; j < UVF; j++) begin : g_div
    localparam int SH = UVF - 1 - j;
    logic [63:0] dsh;
    assign dsh = den[j] << SH;
    always_ff @(posedge clk) begin
      den[j+1] <= den[j];
      if (rem[j] >= dsh) begin
        rem[j+1] <= rem[j] - dsh;
        quo[j+1] <= quo[j] | (UVF'(1) << SH);
      end else begin
        rem[j+1] <= rem[j];
        quo[j+1] <= quo[j];
      end
    end
  end

  always_comb begin
    t_ext = (UVF+1)'(quo[UVF]);
    if (side[NSIDE-1].sy_pos) v_calc = (t_ext >= HALF) ? '0 : HALF - t_ext;
    else v_calc = HALF + t_ext;
    if (v_calc > VMAX) v_calc = VMAX;
  end

  always_ff @(posedge clk) begin
    out_degenerate <= side[NSIDE-1].degenerate;
    v              <= v_calc[UVF-1:0];
  end

endmodule

// File: rtl/spherical_uv_generator.sv
// top level of the spherical uv generator
`timescale 1ns / 1ps
// spherical texture coordinates for a stream of vertices
// channels: a vertex is taken at a clock edge with start high and busy low;
//   each result shows on tex_u, tex_v and degenerate for one cycle with done
//   high, and the receiver cannot hold it off
// configuration: the centre point is written over the apb port at byte
//   addresses 0, 4 and 8 (8-byte stride when coordinates exceed 32 bits)
// throughput: one vertex per cycle; busy only rises if the queue between
//   front end and back end backs up, which a free-running back end prevents
// the path from start to done is set by the 32-step square root and the
//   UV_FRAC_BITS-step divide in series; the cordic for u is shorter and its
//   result is delayed to match
// a vertex equal to the centre gives 0.5 for both outputs with degenerate set
// reset clears the centre registers, the queue and all valid flags; items in
//   flight are dropped
module spherical_uv_generator #(
  parameter int COORD_WIDTH      = spuv_pkg::COORD_WIDTH_DEF,
  parameter int UV_FRAC_BITS     = spuv_pkg::UV_FRAC_BITS_DEF,
  parameter int ANGLE_ITERATIONS = spuv_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            psel,
  input  logic                                            penable,
  input  logic                                            pwrite,
  input  logic [((COORD_WIDTH > 32) ? 5 : 4)-1:0]         paddr,
  input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0]       pwdata,
  output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0]       prdata,
  output logic                                            pready,
  input  logic                                            start,
  output logic                                            busy,
  input  logic signed [COORD_WIDTH-1:0]                   vertex_x,
  input  logic signed [COORD_WIDTH-1:0]                   vertex_y,
  input  logic signed [COORD_WIDTH-1:0]                   vertex_z,
  output logic                                            done,
  output logic [spuv_pkg::OUT_W-1:0]                      tex_u,
  output logic [spuv_pkg::OUT_W-1:0]                      tex_v,
  output logic                                            degenerate
);
  import spuv_pkg::*;

  localparam int PDW    = (COORD_WIDTH > 32) ? 64 : 32;
  localparam int ALSB   = (COORD_WIDTH > 32) ? 3 : 2;
  localparam int LAT_U  = ANGLE_ITERATIONS + 2;
  localparam int LAT_V  = 36 + UV_FRAC_BITS;
  localparam int DLY    = LAT_V - LAT_U;
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam logic [UV_FRAC_BITS-1:0] HALF = UV_FRAC_BITS'(1) << (UV_FRAC_BITS - 1);

  logic signed [COORD_WIDTH-1:0] center_x, center_y, center_z;
  logic [1:0]                    reg_idx;
  logic                          accept, wr_en;
  logic                          push, fifo_empty;
  logic [CNT_W-1:0]              fifo_count;
  spuv_item_t                    front_item, back_item;
  logic [UV_FRAC_BITS-1:0]       u_raw, v_raw;
  logic [UV_FRAC_BITS-1:0]       u_dly [0:DLY-1];
  logic                          vn_degenerate;

  assign reg_idx = paddr[ALSB+1:ALSB];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign accept  = start && !busy;
  assign busy    = (fifo_count >= CNT_W'(FIFO_DEPTH - FRONT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CENTER_X: center_x <= pwdata[COORD_WIDTH-1:0];
        REG_CENTER_Y: center_y <= pwdata[COORD_WIDTH-1:0];
        REG_CENTER_Z: center_z <= pwdata[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CENTER_X: prdata = PDW'($unsigned(center_x));
      REG_CENTER_Y: prdata = PDW'($unsigned(center_y));
      REG_CENTER_Z: prdata = PDW'($unsigned(center_z));
      default:      prdata = '0;
    endcase
  end

  spuv_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk(clk), .rst(rst), .accept(accept),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
    .center_x(center_x), .center_y(center_y), .center_z(center_z),
    .push(push), .item(front_item)
  );

  spuv_fifo #(.WIDTH($bits(spuv_item_t)), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk(clk), .rst(rst), .wr_en(push), .din(front_item),
    .rd_en(1'b1), .dout(back_item), .empty(fifo_empty), .count(fifo_count)
  );

  spuv_cordic #(
    .ANGLE_ITERATIONS(ANGLE_ITERATIONS), .UV_FRAC_BITS(UV_FRAC_BITS)
  ) u_cordic (
    .clk(clk), .item(back_item), .u(u_raw)
  );

  spuv_vnorm #(.UV_FRAC_BITS(UV_FRAC_BITS)) u_vnorm (
    .clk(clk), .rst(rst), .in_valid(!fifo_empty), .item(back_item),
    .out_valid(done), .out_degenerate(vn_degenerate), .v(v_raw)
  );

  // line up the short angle path with the root and divide path
  always_ff @(posedge clk) begin
    u_dly[0] <= u_raw;
    for (int k = 1; k < DLY; k++) u_dly[k] <= u_dly[k-1];
  end

  assign degenerate = vn_degenerate;
  assign tex_u = OUT_W'(32'(vn_degenerate ? HALF : u_dly[DLY-1]));
  assign tex_v = OUT_W'(32'(vn_degenerate ? HALF : v_raw));

endmodule

// File: rtl/spuv_checker.sv
// port-level checks for the spherical uv generator, bound to the top level
`timescale 1ns / 1ps
module spuv_checker #(
  parameter int UV_FRAC_BITS = spuv_pkg::UV_FRAC_BITS_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic [spuv_pkg::OUT_W-1:0] tex_u,
  input logic [spuv_pkg::OUT_W-1:0] tex_v,
  input logic                       degenerate
);
  import spuv_pkg::*;

  localparam logic [OUT_W-1:0] HALF16 = OUT_W'(32'd1 << (UV_FRAC_BITS - 1));
  localparam int LAT = 40 + UV_FRAC_BITS;

  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_no_busy_after_reset: assert property (@(posedge clk) rst |=> !busy)
    else $error("busy right after reset");

  a_degenerate_half: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> tex_u == HALF16 && tex_v == HALF16)
    else $error("degenerate result not at the centre of the map");

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a transaction at the fixed latency");

endmodule

bind spherical_uv_generator spuv_checker #(.UV_FRAC_BITS(UV_FRAC_BITS)) u_spuv_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .tex_u(tex_u), .tex_v(tex_v), .degenerate(degenerate)
);
